// ===== sv/hdmm_pkg.sv =====
// Package for the H-drive motor mixer: field widths, register indexes,
// command shaping, channel saturation and the duty scale. No dependencies.
package hdmm_pkg;

  localparam int CMD_W  = 10;  // signed command word
  localparam int CFG_W  = 9;   // widest configuration register
  localparam int MASK_W = 4;   // one invert bit per motor
  localparam int PCT_W  = 8;   // signed percentage, -100..100
  localparam int MAG_W  = 7;   // percentage magnitude, 0..100
  localparam int DUTY_W = 8;
  localparam int NUM_CH = 4;   // left, right, strafe, lift

  // Channel order matches the invert mask bits
  localparam int CH_LEFT   = 0;
  localparam int CH_RIGHT  = 1;
  localparam int CH_STRAFE = 2;
  localparam int CH_LIFT   = 3;

  // Register reset values
  localparam logic [CFG_W-1:0]  DEADBAND_RST    = 9'd5;
  localparam logic [CFG_W-1:0]  SCALE_LIMIT_RST = 9'd100;
  localparam logic [MASK_W-1:0] INVERT_MASK_RST = 4'd0;

  // Percentage saturation bounds
  localparam logic signed [11:0] PCT_HI = 12'sd100;
  localparam logic signed [11:0] PCT_LO = -12'sd100;

  // mag*255/100 as mag*DUTY_RECIP >> DUTY_SHIFT, exact for mag in 0..100
  localparam int DUTY_SHIFT = 19;
  localparam logic [27:0] DUTY_RECIP = 28'd1336965;

  typedef enum logic [1:0] {
    CFG_DEADBAND    = 2'd0,
    CFG_SCALE_LIMIT = 2'd1,
    CFG_INVERT_MASK = 2'd2
  } cfg_idx_t;

  // One motor's bridge controls
  typedef struct packed {
    logic              dir_a;
    logic              dir_b;
    logic [DUTY_W-1:0] duty;
  } chan_t;

  // Deadband then symmetric clamp
  function automatic logic signed [CMD_W-1:0] shape_cmd(
    input logic signed [CMD_W-1:0] v,
    input logic [CFG_W-1:0]        db,
    input logic [CFG_W-1:0]        lim
  );
    logic signed [CMD_W:0] vx;
    logic signed [CMD_W:0] lim_p;
    logic signed [CMD_W:0] lim_n;
    logic signed [CMD_W:0] res;
    logic [CMD_W-1:0]      mag;
    vx    = {v[CMD_W-1], v};
    mag   = vx[CMD_W] ? CMD_W'(-vx) : vx[CMD_W-1:0];
    if (mag < {1'b0, db}) begin
      vx = '0;
    end
    lim_p = $signed({2'b00, lim});
    lim_n = -lim_p;
    if (vx < lim_n) begin
      res = lim_n;
    end else if (vx > lim_p) begin
      res = lim_p;
    end else begin
      res = vx;
    end
    return $signed(res[CMD_W-1:0]);
  endfunction

  // Optional negation then saturation to -100..100
  function automatic logic signed [PCT_W-1:0] sat_pct(
    input logic signed [11:0] p,
    input logic               inv
  );
    logic signed [11:0] q;
    logic signed [11:0] r;
    q = inv ? -p : p;
    if (q < PCT_LO) begin
      r = PCT_LO;
    end else if (q > PCT_HI) begin
      r = PCT_HI;
    end else begin
      r = q;
    end
    return $signed(r[PCT_W-1:0]);
  endfunction

  // Direction bits and duty from a saturated percentage
  function automatic chan_t drive_chan(input logic signed [PCT_W-1:0] pct);
    logic [PCT_W-1:0] neg;
    logic [MAG_W-1:0] mag;
    logic [27:0]      prod;
    chan_t            c;
    neg     = -pct;
    mag     = pct[PCT_W-1] ? neg[MAG_W-1:0] : pct[MAG_W-1:0];
    prod    = 28'(mag) * DUTY_RECIP;
    c.dir_a = !pct[PCT_W-1] && (pct != '0);
    c.dir_b = pct[PCT_W-1];
    c.duty  = prod[DUTY_SHIFT +: DUTY_W];
    return c;
  endfunction

endpackage

// ===== sv/h_drive_motor_mixer.sv =====
// Top level of the H-drive motor mixer: three-stage pipeline plus
// configuration registers. Depends on hdmm_pkg.
//
//  channel  ports                          handshake
//  -------  -----------------------------  ------------------------------
//  input    in_*_cmd (4 x 10 bit signed)   word taken when start && !busy
//  result   out_<motor>_dir_a/_dir_b/_duty word valid while out_valid high
//  config   cfg_we, cfg_index, cfg_wdata   written when cfg_we high
//
// One word per cycle; each word passes through the shape, mix/saturate and
// direction/duty stage registers before it appears on the result ports.
// busy is always low: the pipeline never holds a word back.
// rst_n is synchronous; it clears the stage valid bits and loads the
// register defaults (deadband 5, scale limit 100, no inversion).
// The receiver cannot stall, so results stream out as they complete.
module h_drive_motor_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [hdmm_pkg::CMD_W-1:0]  in_strafe_cmd,
  input  logic signed [hdmm_pkg::CMD_W-1:0]  in_forward_cmd,
  input  logic signed [hdmm_pkg::CMD_W-1:0]  in_turn_cmd,
  input  logic signed [hdmm_pkg::CMD_W-1:0]  in_lift_cmd,
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [hdmm_pkg::CFG_W-1:0]         cfg_wdata,
  // result channel
  output logic                               out_valid,
  output logic                               out_left_dir_a,
  output logic                               out_left_dir_b,
  output logic [hdmm_pkg::DUTY_W-1:0]        out_left_duty,
  output logic                               out_right_dir_a,
  output logic                               out_right_dir_b,
  output logic [hdmm_pkg::DUTY_W-1:0]        out_right_duty,
  output logic                               out_strafe_dir_a,
  output logic                               out_strafe_dir_b,
  output logic [hdmm_pkg::DUTY_W-1:0]        out_strafe_duty,
  output logic                               out_lift_dir_a,
  output logic                               out_lift_dir_b,
  output logic [hdmm_pkg::DUTY_W-1:0]        out_lift_duty
);

  logic [hdmm_pkg::CFG_W-1:0]  deadband_r;
  logic [hdmm_pkg::CFG_W-1:0]  scale_limit_r;
  logic [hdmm_pkg::MASK_W-1:0] invert_mask_r;

  logic accept;

  // stage 1: shaped commands
  logic                              s1_valid_r;
  logic signed [hdmm_pkg::CMD_W-1:0] s1_strafe_r, s1_forward_r, s1_turn_r, s1_lift_r;

  // stage 2: saturated percentages, one per motor
  logic                              s2_valid_r;
  logic signed [hdmm_pkg::PCT_W-1:0] s2_pct_r [hdmm_pkg::NUM_CH];
  logic signed [11:0]                mix_left, mix_right, mix_strafe, mix_lift;

  // stage 3: bridge controls
  logic            s3_valid_r;
  hdmm_pkg::chan_t s3_chan_r [hdmm_pkg::NUM_CH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= hdmm_pkg::DEADBAND_RST;
      scale_limit_r <= hdmm_pkg::SCALE_LIMIT_RST;
      invert_mask_r <= hdmm_pkg::INVERT_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hdmm_pkg::CFG_DEADBAND:    deadband_r    <= cfg_wdata;
        hdmm_pkg::CFG_SCALE_LIMIT: scale_limit_r <= cfg_wdata;
        hdmm_pkg::CFG_INVERT_MASK: invert_mask_r <= cfg_wdata[hdmm_pkg::MASK_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // valid bits travel with the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // stage 1: deadband and clamp on each command
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_strafe_r  <= hdmm_pkg::shape_cmd(in_strafe_cmd,  deadband_r, scale_limit_r);
      s1_forward_r <= hdmm_pkg::shape_cmd(in_forward_cmd, deadband_r, scale_limit_r);
      s1_turn_r    <= hdmm_pkg::shape_cmd(in_turn_cmd,    deadband_r, scale_limit_r);
      s1_lift_r    <= hdmm_pkg::shape_cmd(in_lift_cmd,    deadband_r, scale_limit_r);
    end
  end

  // stage 2: mix side motors, invert, saturate
  always_comb begin
    mix_left   = $signed({{2{s1_forward_r[9]}}, s1_forward_r})
               + $signed({{2{s1_turn_r[9]}}, s1_turn_r});
    mix_right  = $signed({{2{s1_forward_r[9]}}, s1_forward_r})
               - $signed({{2{s1_turn_r[9]}}, s1_turn_r});
    mix_strafe = $signed({{2{s1_strafe_r[9]}}, s1_strafe_r});
    mix_lift   = $signed({{2{s1_lift_r[9]}}, s1_lift_r});
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_pct_r[hdmm_pkg::CH_LEFT]   <= hdmm_pkg::sat_pct(mix_left,
                                         invert_mask_r[hdmm_pkg::CH_LEFT]);
      s2_pct_r[hdmm_pkg::CH_RIGHT]  <= hdmm_pkg::sat_pct(mix_right,
                                         invert_mask_r[hdmm_pkg::CH_RIGHT]);
      s2_pct_r[hdmm_pkg::CH_STRAFE] <= hdmm_pkg::sat_pct(mix_strafe,
                                         invert_mask_r[hdmm_pkg::CH_STRAFE]);
      s2_pct_r[hdmm_pkg::CH_LIFT]   <= hdmm_pkg::sat_pct(mix_lift,
                                         invert_mask_r[hdmm_pkg::CH_LIFT]);
    end
  end

  // stage 3: direction bits and duty per motor
  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      for (int i = 0; i < hdmm_pkg::NUM_CH; i++) begin
        s3_chan_r[i] <= hdmm_pkg::drive_chan(s2_pct_r[i]);
      end
    end
  end

  // result ports
  assign out_valid        = s3_valid_r;
  assign out_left_dir_a   = s3_chan_r[hdmm_pkg::CH_LEFT].dir_a;
  assign out_left_dir_b   = s3_chan_r[hdmm_pkg::CH_LEFT].dir_b;
  assign out_left_duty    = s3_chan_r[hdmm_pkg::CH_LEFT].duty;
  assign out_right_dir_a  = s3_chan_r[hdmm_pkg::CH_RIGHT].dir_a;
  assign out_right_dir_b  = s3_chan_r[hdmm_pkg::CH_RIGHT].dir_b;
  assign out_right_duty   = s3_chan_r[hdmm_pkg::CH_RIGHT].duty;
  assign out_strafe_dir_a = s3_chan_r[hdmm_pkg::CH_STRAFE].dir_a;
  assign out_strafe_dir_b = s3_chan_r[hdmm_pkg::CH_STRAFE].dir_b;
  assign out_strafe_duty  = s3_chan_r[hdmm_pkg::CH_STRAFE].duty;
  assign out_lift_dir_a   = s3_chan_r[hdmm_pkg::CH_LIFT].dir_a;
  assign out_lift_dir_b   = s3_chan_r[hdmm_pkg::CH_LIFT].dir_b;
  assign out_lift_duty    = s3_chan_r[hdmm_pkg::CH_LIFT].duty;

endmodule

// ===== sv/hdmm_checker.sv =====
// Port-level checks for the H-drive motor mixer, bound to the top level.
// Depends on h_drive_motor_mixer's port list only.
module hdmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_left_dir_a,
  input logic       out_left_dir_b,
  input logic [7:0] out_left_duty,
  input logic       out_right_dir_a,
  input logic       out_right_dir_b,
  input logic [7:0] out_right_duty,
  input logic       out_strafe_dir_a,
  input logic       out_strafe_dir_b,
  input logic [7:0] out_strafe_duty,
  input logic       out_lift_dir_a,
  input logic       out_lift_dir_b,
  input logic [7:0] out_lift_duty
);

  // every taken word comes out on the result ports
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("word taken but no result three cycles on");

  // no result without a word taken before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching word");

  // a bridge is never driven both ways
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_dir_a && out_left_dir_b) && !(out_right_dir_a && out_right_dir_b)
      && !(out_strafe_dir_a && out_strafe_dir_b) && !(out_lift_dir_a && out_lift_dir_b))
    else $error("both direction bits set");

  // brake exactly when duty is zero
  a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_dir_a || out_left_dir_b) == (out_left_duty != 8'd0))
      && ((out_right_dir_a || out_right_dir_b) == (out_right_duty != 8'd0))
      && ((out_strafe_dir_a || out_strafe_dir_b) == (out_strafe_duty != 8'd0))
      && ((out_lift_dir_a || out_lift_dir_b) == (out_lift_duty != 8'd0)))
    else $error("duty disagrees with direction bits");

endmodule

bind h_drive_motor_mixer hdmm_checker u_hdmm_checker (.*);
